FILE: design/utf8_decoder_with_position_macros.svh
// Assertion macros used by the UTF-8 decoder checker.
`ifndef UTF8_DECODER_WITH_POSITION_MACROS_SVH
`define UTF8_DECODER_WITH_POSITION_MACROS_SVH

// Same-cycle implication, sampled on i_clk, quiet while i_rst_n is low
`define UTF8P_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, quiet while i_rst_n is low
`define UTF8P_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/utf8p_pkg.sv
// Types, constants and helpers for the UTF-8 decoder with position tracking.
package utf8p_pkg;

    localparam int CP_W  = 21;
    localparam int CNT_W = 32;

    localparam logic [CP_W-1:0]  REPL_CP    = 21'h00FFFD;
    localparam logic [CP_W-1:0]  NEWLINE_CP = 21'h00000A;
    localparam logic [CP_W-1:0]  MIN_CP_2   = 21'h000080;
    localparam logic [CP_W-1:0]  MIN_CP_3   = 21'h000800;
    localparam logic [CP_W-1:0]  MIN_CP_4   = 21'h010000;
    localparam logic [CP_W-1:0]  MAX_CP     = 21'h10FFFF;
    localparam logic [CNT_W-1:0] CNT_MAX    = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0] CNT_ONE    = 32'd1;

    // Sequence lengths held in the needed-length register
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } t_lead;

    // Head result offered by the decoder to the output stage
    typedef struct packed {
        logic            vld;
        logic [CP_W-1:0] cp;
        logic            last;
    } t_head;

    // Classify a byte taken as the start of a sequence
    function automatic t_lead classify_lead(input logic [7:0] b);
        t_lead k;
        case (b) inside
            [8'h00:8'h7F]: k = LEAD_ASCII;
            [8'hC0:8'hDF]: k = LEAD_TWO;
            [8'hE0:8'hEF]: k = LEAD_THREE;
            [8'hF0:8'hF7]: k = LEAD_FOUR;
            default:       k = LEAD_BAD;
        endcase
        return k;
    endfunction

endpackage

FILE: design/utf8p_if.sv
// Valid/ready channel interfaces for the byte input and the code point output.
interface utf8p_in_if import utf8p_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, data_byte, end_of_text, input ready);
    modport sink   (input valid, data_byte, end_of_text, output ready);
endinterface

interface utf8p_out_if import utf8p_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CP_W-1:0]  code_point;
    logic [CNT_W-1:0] line_number;
    logic [CNT_W-1:0] column_number;
    logic             error_seen;
    logic             last_of_run;

    modport source (output valid, code_point, line_number, column_number, error_seen,
                    last_of_run, input ready);
    modport sink   (input valid, code_point, line_number, column_number, error_seen,
                    last_of_run, output ready);
endinterface

FILE: design/utf8p_decode.sv
// Byte decoder: sequence state and the run register of pending results.
module utf8p_decode import utf8p_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    utf8p_in_if.sink   i_data_ch,
    input  logic       i_take,
    output t_head      o_head
);

    // Sequence state
    logic [1:0]       r_hc, n_hc;
    logic [2:0]       r_nl, n_nl;
    logic [7:0]       r_held [3];
    logic [7:0]       n_held [3];

    // Run register: replacement count, then an optional tail code point
    logic [2:0]       r_rep, n_rep;
    logic             r_tail_vld, n_tail_vld;
    logic [CP_W-1:0]  r_tail_cp, n_tail_cp;

    logic             accept;
    logic             pop;
    logic [7:0]       b;
    logic             is_cont;
    logic             do_lead;
    t_lead            lead;
    logic [CP_W-1:0]  seq_cp;
    logic             seq_ok;

    assign b       = i_data_ch.data_byte;
    assign is_cont = (b[7:6] == 2'b10);
    assign lead    = classify_lead(b);

    // Head of the run: replacements first, then the tail
    always_comb begin
        o_head.vld  = (r_rep != 3'd0) || r_tail_vld;
        o_head.cp   = (r_rep != 3'd0) ? REPL_CP : r_tail_cp;
        o_head.last = ((r_rep == 3'd1) && !r_tail_vld) || ((r_rep == 3'd0) && r_tail_vld);
    end

    assign pop             = o_head.vld && i_take;
    assign i_data_ch.ready = !o_head.vld || (pop && o_head.last);
    assign accept          = i_data_ch.valid && i_data_ch.ready;

    // Assemble and range-check a completed sequence
    always_comb begin
        case (r_nl)
            LEN_TWO: begin
                seq_cp = {10'd0, r_held[0][4:0], b[5:0]};
                seq_ok = (seq_cp >= MIN_CP_2);
            end
            LEN_THREE: begin
                seq_cp = {5'd0, r_held[0][3:0], r_held[1][5:0], b[5:0]};
                seq_ok = (seq_cp >= MIN_CP_3);
            end
            default: begin
                seq_cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0], b[5:0]};
                seq_ok = (seq_cp >= MIN_CP_4) && (seq_cp <= MAX_CP);
            end
        endcase
    end

    // Next sequence state and the results this byte causes
    always_comb begin
        n_hc       = r_hc;
        n_nl       = r_nl;
        n_held     = r_held;
        n_rep      = 3'd0;
        n_tail_vld = 1'b0;
        n_tail_cp  = b[7:0] == 8'd0 ? '0 : {13'd0, b};
        do_lead    = 1'b0;

        if (r_hc == 2'd0) begin
            do_lead = 1'b1;
        end else if (is_cont) begin
            if ({1'b0, r_hc} + 3'd1 >= r_nl) begin
                if (seq_ok) begin
                    n_tail_vld = 1'b1;
                    n_tail_cp  = seq_cp;
                end else begin
                    n_rep = r_nl;
                end
                n_hc = 2'd0;
                n_nl = LEN_NONE;
            end else begin
                n_held[r_hc] = b;
                n_hc         = r_hc + 2'd1;
            end
        end else begin
            // interrupted: one replacement per held byte, then b is a new lead
            n_rep   = {1'b0, r_hc};
            n_hc    = 2'd0;
            n_nl    = LEN_NONE;
            do_lead = 1'b1;
        end

        if (do_lead) begin
            case (lead)
                LEAD_ASCII: begin
                    n_tail_vld = 1'b1;
                    n_tail_cp  = {13'd0, b};
                end
                LEAD_BAD: begin
                    n_tail_vld = 1'b1;
                    n_tail_cp  = REPL_CP;
                end
                LEAD_TWO: begin
                    n_held[0] = b;
                    n_hc      = 2'd1;
                    n_nl      = LEN_TWO;
                end
                LEAD_THREE: begin
                    n_held[0] = b;
                    n_hc      = 2'd1;
                    n_nl      = LEN_THREE;
                end
                default: begin
                    n_held[0] = b;
                    n_hc      = 2'd1;
                    n_nl      = LEN_FOUR;
                end
            endcase
        end

        // end of text flushes whatever is still held
        if (i_data_ch.end_of_text && (n_hc != 2'd0)) begin
            n_rep = n_rep + {1'b0, n_hc};
            n_hc  = 2'd0;
            n_nl  = LEN_NONE;
        end
    end

    // Sequence state and run control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc       <= 2'd0;
            r_nl       <= LEN_NONE;
            r_rep      <= 3'd0;
            r_tail_vld <= 1'b0;
        end else if (accept) begin
            r_hc       <= n_hc;
            r_nl       <= n_nl;
            r_rep      <= n_rep;
            r_tail_vld <= n_tail_vld;
        end else if (pop) begin
            if (r_rep != 3'd0) begin
                r_rep <= r_rep - 3'd1;
            end else begin
                r_tail_vld <= 1'b0;
            end
        end
    end

    // Payload: held bytes and tail value
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held    <= n_held;
            r_tail_cp <= n_tail_cp;
        end
    end

endmodule

FILE: design/utf8p_emit.sv
// Output stage: result register with line, column and sticky error tracking.
module utf8p_emit import utf8p_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_head      i_head,
    output logic       o_take,
    utf8p_out_if.source o_result_ch
);

    logic             r_out_vld;
    logic [CP_W-1:0]  r_cp;
    logic [CNT_W-1:0] r_out_line, r_out_col;
    logic             r_out_err;
    logic             r_out_last;

    logic [CNT_W-1:0] r_line, n_line;
    logic [CNT_W-1:0] r_col, n_col;
    logic             r_err, n_err;
    logic             load;

    assign o_take = !r_out_vld || o_result_ch.ready;
    assign load   = o_take && i_head.vld;

    // Position and error flag after this result
    always_comb begin
        n_err  = r_err || (i_head.cp == REPL_CP);
        n_line = r_line;
        n_col  = r_col;
        if (i_head.cp == NEWLINE_CP) begin
            if (r_line != CNT_MAX) begin
                n_line = r_line + CNT_ONE;
            end
            n_col = CNT_ONE;
        end else if (r_col != CNT_MAX) begin
            n_col = r_col + CNT_ONE;
        end
    end

    // Control: valid flag and running counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_line    <= CNT_ONE;
            r_col     <= CNT_ONE;
            r_err     <= 1'b0;
        end else begin
            if (o_take) begin
                r_out_vld <= i_head.vld;
            end
            if (load) begin
                r_line <= n_line;
                r_col  <= n_col;
                r_err  <= n_err;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp       <= i_head.cp;
            r_out_line <= r_line;
            r_out_col  <= r_col;
            r_out_err  <= n_err;
            r_out_last <= i_head.last;
        end
    end

    assign o_result_ch.valid         = r_out_vld;
    assign o_result_ch.code_point    = r_cp;
    assign o_result_ch.line_number   = r_out_line;
    assign o_result_ch.column_number = r_out_col;
    assign o_result_ch.error_seen    = r_out_err;
    assign o_result_ch.last_of_run   = r_out_last;

endmodule

FILE: design/utf8_decoder_with_position.sv
// A byte's results go from the decoder's run register into the output register, from which
// they are transferred. Throughput: one byte per cycle while each byte gives at most one
// result and the output is not stalled; a byte that gives several results (up to four)
// holds the input until the one-result-per-cycle output register has taken its last one.
// Bytes that only extend a sequence give no result.
// Reset (synchronous, active low) clears the sequence state and the pending results,
// sets line and column to one and clears the error flag; held bytes are not reset.
module utf8_decoder_with_position import utf8p_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    utf8p_in_if.sink    i_data_ch,
    utf8p_out_if.source o_result_ch
);

    t_head head;
    logic  take;

    // Decode bytes into runs of results
    utf8p_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_data_ch (i_data_ch),
        .i_take    (take),
        .o_head    (head)
    );

    // Tag results with position and error flag
    utf8p_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_take      (take),
        .o_result_ch (o_result_ch)
    );

endmodule

FILE: design/utf8p_checker.sv
// Port-level checker for the UTF-8 decoder, bound to the top level.
`include "utf8_decoder_with_position_macros.svh"

module utf8p_checker import utf8p_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [CP_W-1:0]  i_code_point,
    input logic [CNT_W-1:0] i_line_number,
    input logic [CNT_W-1:0] i_column_number,
    input logic             i_error_seen,
    input logic             i_last_of_run
);

    logic xfer;
    logic r_err_shown;

    assign xfer = i_out_valid && i_out_ready;

    // Remember that an error flag has been transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_shown <= 1'b0;
        end else if (xfer && i_error_seen) begin
            r_err_shown <= 1'b1;
        end
    end

    `UTF8P_ASSERT_NXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_code_point) && $stable(i_line_number) && $stable(i_column_number) && $stable(i_error_seen) && $stable(i_last_of_run), "result changed while stalled")
    `UTF8P_ASSERT_IMP(a_err_sticky, xfer && r_err_shown, i_error_seen, "error flag dropped")
    `UTF8P_ASSERT_IMP(a_repl_flags, xfer && (i_code_point == REPL_CP), i_error_seen, "replacement without error flag")
    `UTF8P_ASSERT_IMP(a_cp_range, xfer, i_code_point <= MAX_CP, "code point out of range")
    `UTF8P_ASSERT_IMP(a_pos_nonzero, xfer, (i_line_number != '0) && (i_column_number != '0), "zero line or column")

endmodule

bind utf8_decoder_with_position utf8p_checker u_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result_ch.valid),
    .i_out_ready     (o_result_ch.ready),
    .i_code_point    (o_result_ch.code_point),
    .i_line_number   (o_result_ch.line_number),
    .i_column_number (o_result_ch.column_number),
    .i_error_seen    (o_result_ch.error_seen),
    .i_last_of_run   (o_result_ch.last_of_run)
);
